// File: hw/rtl/wsht_pkg.sv
// shared constants, codes and controller/datapath types for the window stack
`timescale 1ns / 1ps
package wsht_pkg;

  localparam int unsigned MaxWindows  = 6;
  localparam int unsigned CoordBits   = 12;
  localparam int unsigned IdBits      = 4;
  localparam int unsigned SlotBits    = $clog2(MaxWindows);
  localparam int unsigned CountBits   = $clog2(MaxWindows + 1);
  localparam int unsigned OpBits      = 2;
  localparam int unsigned StatusBits  = 2;
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = CoordBits;

  typedef logic [CoordBits-1:0] coord_t;
  typedef logic [IdBits-1:0]    id_t;
  typedef logic [CountBits-1:0] count_t;
  typedef logic [SlotBits-1:0]  slot_t;

  typedef enum logic [OpBits-1:0] {
    OpAdd    = 2'd0,
    OpRaise  = 2'd1,
    OpRemove = 2'd2,
    OpFind   = 2'd3
  } op_e;

  typedef enum logic [StatusBits-1:0] {
    StOk      = 2'd0,
    StPresent = 2'd1,
    StFull    = 2'd2,
    StAbsent  = 2'd3
  } status_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgPanelEnable = 3'd0,
    CfgPanelId     = 3'd1,
    CfgPanelX      = 3'd2,
    CfgPanelY      = 3'd3,
    CfgPanelW      = 3'd4,
    CfgPanelH      = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic load;
    logic scan;
    logic apply;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
  } dp_stat_t;

endpackage

// File: hw/rtl/wsht_ctrl.sv
// controller state machine: sequences load, slot scan and stack update
`timescale 1ns / 1ps
module wsht_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  output logic               done_o,
  output wsht_pkg::dp_cmd_t  cmd_o,
  input  wsht_pkg::dp_stat_t stat_i
);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StApply
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   done_q;

  assign cmd_o.load  = start_i & ~busy_q;
  assign cmd_o.scan  = (state_q == StScan) & ~stat_i.done;
  assign cmd_o.apply = (state_q == StApply);

  assign busy_o = busy_q;
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (start_i) begin
            state_q <= StScan;
            busy_q  <= 1'b1;
          end
        end
        StScan: begin
          if (stat_i.done) begin
            state_q <= StApply;
          end
        end
        StApply: begin
          state_q <= StIdle;
          busy_q  <= 1'b0;
          done_q  <= 1'b1;
        end
        default: begin
          state_q <= StIdle;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe held longer than one cycle");

  a_apply_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StApply) |=> (done_q && !busy_q))
    else $error("update cycle not followed by a result word");

  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_q) |=> (state_q == StScan && busy_q && !done_q))
    else $error("accepted word did not start a scan");

endmodule

// File: hw/rtl/wsht_dp.sv
// datapath: window stack slots, panel registers, slot scan and result registers
`timescale 1ns / 1ps
module wsht_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  wsht_pkg::dp_cmd_t                    cmd_i,
  output wsht_pkg::dp_stat_t                   stat_o,
  input  logic                                 cfg_we_i,
  input  logic [wsht_pkg::CfgIdxBits-1:0]      cfg_index_i,
  input  logic [wsht_pkg::CfgDataBits-1:0]     cfg_data_i,
  input  logic [wsht_pkg::OpBits-1:0]          operation_i,
  input  wsht_pkg::id_t                        window_id_i,
  input  wsht_pkg::coord_t                     rect_x_i,
  input  wsht_pkg::coord_t                     rect_y_i,
  input  wsht_pkg::coord_t                     rect_w_i,
  input  wsht_pkg::coord_t                     rect_h_i,
  input  wsht_pkg::coord_t                     point_x_i,
  input  wsht_pkg::coord_t                     point_y_i,
  output logic [wsht_pkg::StatusBits-1:0]      status_o,
  output logic                                 hit_found_o,
  output wsht_pkg::id_t                        hit_id_o,
  output logic                                 hit_is_panel_o,
  output logic                                 top_valid_o,
  output wsht_pkg::id_t                        top_id_o,
  output wsht_pkg::count_t                     window_count_o
);

  function automatic logic contains(wsht_pkg::coord_t x, wsht_pkg::coord_t y,
                                    wsht_pkg::coord_t w, wsht_pkg::coord_t h,
                                    wsht_pkg::coord_t px, wsht_pkg::coord_t py);
    logic [wsht_pkg::CoordBits:0] xe;
    logic [wsht_pkg::CoordBits:0] ye;
    xe = {1'b0, x} + {1'b0, w};
    ye = {1'b0, y} + {1'b0, h};
    return (px >= x) && ({1'b0, px} < xe) && (py >= y) && ({1'b0, py} < ye);
  endfunction

  // panel registers
  logic             pen_q;
  wsht_pkg::id_t    pid_q;
  wsht_pkg::coord_t pan_x_q, pan_y_q, pan_w_q, pan_h_q;

  // latched word
  wsht_pkg::op_e    op_q;
  wsht_pkg::id_t    id_q;
  wsht_pkg::coord_t nx_q, ny_q, nw_q, nh_q, px_q, py_q;
  logic             panel_hit_q;

  // stack slots, slot 0 on top
  wsht_pkg::count_t count_q, count_d;
  wsht_pkg::count_t idx_q;
  wsht_pkg::id_t    ids_q [wsht_pkg::MaxWindows];
  wsht_pkg::id_t    ids_d [wsht_pkg::MaxWindows];
  wsht_pkg::coord_t rx_q  [wsht_pkg::MaxWindows];
  wsht_pkg::coord_t rx_d  [wsht_pkg::MaxWindows];
  wsht_pkg::coord_t ry_q  [wsht_pkg::MaxWindows];
  wsht_pkg::coord_t ry_d  [wsht_pkg::MaxWindows];
  wsht_pkg::coord_t rw_q  [wsht_pkg::MaxWindows];
  wsht_pkg::coord_t rw_d  [wsht_pkg::MaxWindows];
  wsht_pkg::coord_t rh_q  [wsht_pkg::MaxWindows];
  wsht_pkg::coord_t rh_d  [wsht_pkg::MaxWindows];

  // result word
  wsht_pkg::status_e status_q, status_d;
  logic              hitf_q, hitf_d;
  wsht_pkg::id_t     hid_q, hid_d;
  logic              hpan_q, hpan_d;
  logic              topv_q;
  wsht_pkg::id_t     topid_q;
  wsht_pkg::count_t  wcount_q;

  logic             in_range;
  wsht_pkg::slot_t  sel;
  wsht_pkg::id_t    cur_id;
  wsht_pkg::coord_t cur_x, cur_y, cur_w, cur_h;
  logic             cur_match;
  logic             load_panel_hit;

  assign in_range = (idx_q < count_q);
  assign sel      = in_range ? idx_q[wsht_pkg::SlotBits-1:0] : '0;
  assign cur_id   = ids_q[sel];
  assign cur_x    = rx_q[sel];
  assign cur_y    = ry_q[sel];
  assign cur_w    = rw_q[sel];
  assign cur_h    = rh_q[sel];

  assign cur_match = in_range &&
                     ((op_q == wsht_pkg::OpFind) ?
                      contains(cur_x, cur_y, cur_w, cur_h, px_q, py_q) :
                      (cur_id == id_q));

  assign stat_o.done = panel_hit_q | cur_match | ~in_range;

  assign load_panel_hit = pen_q &&
                          (wsht_pkg::op_e'(operation_i) == wsht_pkg::OpFind) &&
                          contains(pan_x_q, pan_y_q, pan_w_q, pan_h_q,
                                   point_x_i, point_y_i);

  always_comb begin
    count_d  = count_q;
    ids_d    = ids_q;
    rx_d     = rx_q;
    ry_d     = ry_q;
    rw_d     = rw_q;
    rh_d     = rh_q;
    status_d = wsht_pkg::StOk;
    hitf_d   = 1'b0;
    hid_d    = '0;
    hpan_d   = 1'b0;
    case (op_q)
      wsht_pkg::OpAdd: begin
        if (cur_match) begin
          status_d = wsht_pkg::StPresent;
        end else if (count_q == wsht_pkg::CountBits'(wsht_pkg::MaxWindows)) begin
          status_d = wsht_pkg::StFull;
        end else begin
          for (int i = 1; i < wsht_pkg::MaxWindows; i++) begin
            ids_d[i] = ids_q[i-1];
            rx_d[i]  = rx_q[i-1];
            ry_d[i]  = ry_q[i-1];
            rw_d[i]  = rw_q[i-1];
            rh_d[i]  = rh_q[i-1];
          end
          ids_d[0] = id_q;
          rx_d[0]  = nx_q;
          ry_d[0]  = ny_q;
          rw_d[0]  = nw_q;
          rh_d[0]  = nh_q;
          count_d  = count_q + 1'b1;
        end
      end
      wsht_pkg::OpRaise: begin
        if (!cur_match) begin
          status_d = wsht_pkg::StAbsent;
        end else begin
          for (int i = 1; i < wsht_pkg::MaxWindows; i++) begin
            if (wsht_pkg::SlotBits'(i) <= sel) begin
              ids_d[i] = ids_q[i-1];
              rx_d[i]  = rx_q[i-1];
              ry_d[i]  = ry_q[i-1];
              rw_d[i]  = rw_q[i-1];
              rh_d[i]  = rh_q[i-1];
            end
          end
          ids_d[0] = cur_id;
          rx_d[0]  = cur_x;
          ry_d[0]  = cur_y;
          rw_d[0]  = cur_w;
          rh_d[0]  = cur_h;
        end
      end
      wsht_pkg::OpRemove: begin
        if (!cur_match) begin
          status_d = wsht_pkg::StAbsent;
        end else begin
          for (int i = 0; i < wsht_pkg::MaxWindows - 1; i++) begin
            if (wsht_pkg::SlotBits'(i) >= sel) begin
              ids_d[i] = ids_q[i+1];
              rx_d[i]  = rx_q[i+1];
              ry_d[i]  = ry_q[i+1];
              rw_d[i]  = rw_q[i+1];
              rh_d[i]  = rh_q[i+1];
            end
          end
          count_d = count_q - 1'b1;
        end
      end
      wsht_pkg::OpFind: begin
        if (panel_hit_q) begin
          hitf_d = 1'b1;
          hid_d  = pid_q;
          hpan_d = 1'b1;
        end else if (cur_match) begin
          hitf_d = 1'b1;
          hid_d  = cur_id;
        end
      end
      default: begin
        status_d = wsht_pkg::StOk;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_q       <= 1'b0;
      pid_q       <= '0;
      pan_x_q     <= '0;
      pan_y_q     <= '0;
      pan_w_q     <= '0;
      pan_h_q     <= '0;
      op_q        <= wsht_pkg::OpAdd;
      panel_hit_q <= 1'b0;
      idx_q       <= '0;
      count_q     <= '0;
      for (int i = 0; i < wsht_pkg::MaxWindows; i++) begin
        ids_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (wsht_pkg::cfg_reg_e'(cfg_index_i))
          wsht_pkg::CfgPanelEnable: pen_q   <= cfg_data_i[0];
          wsht_pkg::CfgPanelId:     pid_q   <= cfg_data_i[wsht_pkg::IdBits-1:0];
          wsht_pkg::CfgPanelX:      pan_x_q <= cfg_data_i[wsht_pkg::CoordBits-1:0];
          wsht_pkg::CfgPanelY:      pan_y_q <= cfg_data_i[wsht_pkg::CoordBits-1:0];
          wsht_pkg::CfgPanelW:      pan_w_q <= cfg_data_i[wsht_pkg::CoordBits-1:0];
          wsht_pkg::CfgPanelH:      pan_h_q <= cfg_data_i[wsht_pkg::CoordBits-1:0];
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        op_q        <= wsht_pkg::op_e'(operation_i);
        panel_hit_q <= load_panel_hit;
        idx_q       <= '0;
      end else if (cmd_i.scan) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.apply) begin
        count_q <= count_d;
        ids_q   <= ids_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      id_q <= window_id_i;
      nx_q <= rect_x_i;
      ny_q <= rect_y_i;
      nw_q <= rect_w_i;
      nh_q <= rect_h_i;
      px_q <= point_x_i;
      py_q <= point_y_i;
    end
    if (cmd_i.apply) begin
      rx_q     <= rx_d;
      ry_q     <= ry_d;
      rw_q     <= rw_d;
      rh_q     <= rh_d;
      status_q <= status_d;
      hitf_q   <= hitf_d;
      hid_q    <= hid_d;
      hpan_q   <= hpan_d;
      topv_q   <= (count_d != '0);
      topid_q  <= (count_d != '0) ? ids_d[0] : '0;
      wcount_q <= count_d;
    end
  end

  assign status_o       = status_q;
  assign hit_found_o    = hitf_q;
  assign hit_id_o       = hid_q;
  assign hit_is_panel_o = hpan_q;
  assign top_valid_o    = topv_q;
  assign top_id_o       = topid_q;
  assign window_count_o = wcount_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= wsht_pkg::CountBits'(wsht_pkg::MaxWindows))
    else $error("window count above stack depth");

  a_find_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.apply && op_q == wsht_pkg::OpFind) |=> (status_q == wsht_pkg::StOk))
    else $error("find reported a non-ok status");

  a_remove_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.apply && op_q == wsht_pkg::OpRemove && cur_match) |=>
      (count_q == wsht_pkg::CountBits'($past(count_q) - 1'b1)))
    else $error("remove did not shrink the stack by one");

endmodule

// File: hw/rtl/window_stack_with_hit_test_top.sv
// top level of the window stack with point hit test
`timescale 1ns / 1ps
// usage
//   command channel: a word is taken at a rising edge with start high and busy low;
//   it carries operation, window id, rectangle and point on separate ports
//   result channel: done_o is high for exactly one cycle with the result word on
//   the result ports; the receiver cannot stall it and must take it in that cycle
//   config channel: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
//   ready is always high, write only while the block is idle
// timing
//   slots are scanned one per cycle from the top until the id or point matches
//   or the stack end is reached (a panel hit ends the scan at once); the stack
//   is then updated in the apply state, and done_o is registered from that
//   state, with busy falling at the same time as done_o rises;
//   the next word is taken only once busy is low, so a word is not taken
//   before the block is through with the last one
// reset
//   asynchronous active low; stack empty, panel disabled, all panel fields zero
module window_stack_with_hit_test_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  output logic                                 done_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [wsht_pkg::CfgIdxBits-1:0]      cfg_index_i,
  input  logic [wsht_pkg::CfgDataBits-1:0]     cfg_data_i,
  input  logic [wsht_pkg::OpBits-1:0]          operation_i,
  input  logic [wsht_pkg::IdBits-1:0]          window_id_i,
  input  logic [wsht_pkg::CoordBits-1:0]       rect_x_i,
  input  logic [wsht_pkg::CoordBits-1:0]       rect_y_i,
  input  logic [wsht_pkg::CoordBits-1:0]       rect_w_i,
  input  logic [wsht_pkg::CoordBits-1:0]       rect_h_i,
  input  logic [wsht_pkg::CoordBits-1:0]       point_x_i,
  input  logic [wsht_pkg::CoordBits-1:0]       point_y_i,
  output logic [wsht_pkg::StatusBits-1:0]      status_o,
  output logic                                 hit_found_o,
  output logic [wsht_pkg::IdBits-1:0]          hit_id_o,
  output logic                                 hit_is_panel_o,
  output logic                                 top_valid_o,
  output logic [wsht_pkg::IdBits-1:0]          top_id_o,
  output logic [wsht_pkg::CountBits-1:0]       window_count_o
);

  wsht_pkg::dp_cmd_t  cmd;
  wsht_pkg::dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  wsht_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .done_o  (done_o),
    .cmd_o   (cmd),
    .stat_i  (stat)
  );

  wsht_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .cfg_we_i       (cfg_valid_i & cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .operation_i    (operation_i),
    .window_id_i    (window_id_i),
    .rect_x_i       (rect_x_i),
    .rect_y_i       (rect_y_i),
    .rect_w_i       (rect_w_i),
    .rect_h_i       (rect_h_i),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .status_o       (status_o),
    .hit_found_o    (hit_found_o),
    .hit_id_o       (hit_id_o),
    .hit_is_panel_o (hit_is_panel_o),
    .top_valid_o    (top_valid_o),
    .top_id_o       (top_id_o),
    .window_count_o (window_count_o)
  );

endmodule
